>>> rtl/core/neighbor_abs_diff_sum_core_assert.svh
// Assertion macros for the neighbor abs-diff-sum core.
// Expects clk and rst_n in the scope of the including module.
`ifndef NEIGHBOR_ABS_DIFF_SUM_CORE_ASSERT_SVH
`define NEIGHBOR_ABS_DIFF_SUM_CORE_ASSERT_SVH

// Same-cycle implication.
`define NADS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NADS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/nads_pkg.sv
// Shared types and constants for the neighbor abs-diff-sum core.
// No dependencies; used by nads_line and neighbor_abs_diff_sum_core.
package nads_pkg;

    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int SUM_W      = 10;
    localparam int TOTAL_W    = 25;
    localparam int FW_W       = 6;
    localparam int FH_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [FH_W-1:0]  MAX_HEIGHT     = 11'd1024;
    localparam int               RST_WIDTH      = 5;
    localparam logic [ROW_W-1:0] RST_LAST_ROW   = 10'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [SUM_W-1:0]   sum;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } result_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } line_ctl_t;

endpackage

>>> rtl/core/nads_line.sv
// Two cascaded variable-length delay lines (one frame row each) with fixed taps.
// Depends on nads_pkg (line_ctl_t).
module nads_line #(
    parameter int DEPTH      = 32,
    parameter int PIXEL_BITS = 8,
    parameter int IDX_W      = 5
) (
    input  logic                     clk,
    input  nads_pkg::line_ctl_t      ctl,
    input  logic [IDX_W-1:0]         ins,
    input  logic [PIXEL_BITS-1:0]    pixel,
    output logic [PIXEL_BITS-1:0]    a_end,
    output logic [PIXEL_BITS-1:0]    a_ahead,
    output logic [PIXEL_BITS-1:0]    a_behind,
    output logic [PIXEL_BITS-1:0]    b_end
);

    logic [PIXEL_BITS-1:0] a_line_reg [DEPTH];
    logic [PIXEL_BITS-1:0] a_line_next [DEPTH];
    logic [PIXEL_BITS-1:0] b_line_reg [DEPTH];
    logic [PIXEL_BITS-1:0] b_line_next [DEPTH];
    logic [PIXEL_BITS-1:0] behind_reg;
    logic [PIXEL_BITS-1:0] a_in;

    // New sample enters at DEPTH - width, so the line length follows frame_width.
    always_comb
    begin
        a_in = ctl.rotate ? a_line_reg[DEPTH-1] : pixel;
        a_line_next[0] = (ins == '0) ? a_in : a_line_reg[0];
        b_line_next[0] = (ins == '0) ? a_line_reg[DEPTH-1] : b_line_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            if (IDX_W'(i) == ins)
            begin
                a_line_next[i] = a_in;
                b_line_next[i] = a_line_reg[DEPTH-1];
            end
            else if (IDX_W'(i) > ins)
            begin
                a_line_next[i] = a_line_reg[i-1];
                b_line_next[i] = b_line_reg[i-1];
            end
            else
            begin
                a_line_next[i] = a_line_reg[i];
                b_line_next[i] = b_line_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            a_line_reg <= a_line_next;
            b_line_reg <= b_line_next;
            behind_reg <= a_line_reg[DEPTH-1];
        end
    end

    assign a_end    = a_line_reg[DEPTH-1];
    assign a_ahead  = a_line_reg[DEPTH-2];
    assign a_behind = behind_reg;
    assign b_end    = b_line_reg[DEPTH-1];

endmodule

>>> rtl/core/neighbor_abs_diff_sum_core.sv
// Order: a pixel's result is registered at the transfer of the pixel below it, in the output
// register, else the skid entry; the last row follows the final transfer.
// Throughput: one pixel per cycle unless stalled; the final frame pixel starts a flush of the
// last row, frame_width results, one per cycle while out_stall is low, in_stall held high.
// in_stall comes from registers only: the skid entry's valid flag and the flush flag.
// Reset: counters, total and valid flags clear; frame size returns to 5 x 5; lines keep data.
module neighbor_abs_diff_sum_core #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [nads_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nads_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [PIXEL_BITS-1:0]               pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [nads_pkg::ROW_W-1:0]          out_row,
    output logic [nads_pkg::COL_W-1:0]          out_col,
    output logic [nads_pkg::SUM_W-1:0]          abs_diff_sum,
    output logic [nads_pkg::TOTAL_W-1:0]        frame_total,
    output logic                                frame_last
);

    `include "neighbor_abs_diff_sum_core_assert.svh"

    localparam int IDX_W   = $clog2(MAX_WIDTH);
    localparam int SW      = PIXEL_BITS + 2;
    localparam int RST_W   = (MAX_WIDTH < nads_pkg::RST_WIDTH) ? MAX_WIDTH : nads_pkg::RST_WIDTH;
    localparam logic [nads_pkg::FW_W-1:0] MAX_W_V = nads_pkg::FW_W'(MAX_WIDTH);

    function automatic logic [PIXEL_BITS-1:0] absdiff(input logic [PIXEL_BITS-1:0] a,
                                                      input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [nads_pkg::COL_W-1:0]   last_col_reg;
    logic [IDX_W-1:0]             ins_reg;
    logic [nads_pkg::ROW_W-1:0]   last_row_reg;
    logic [nads_pkg::ROW_W-1:0]   row_reg;
    logic [nads_pkg::COL_W-1:0]   col_reg;
    logic [nads_pkg::TOTAL_W-1:0] total_reg;
    logic                         flush_active_reg;
    logic [nads_pkg::COL_W-1:0]   flush_col_reg;
    logic [nads_pkg::ROW_W-1:0]   flush_row_reg;

    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    nads_pkg::result_t            out_reg;
    nads_pkg::result_t            skid_reg;

    logic [nads_pkg::FW_W-1:0]    fw;
    logic [nads_pkg::FW_W-1:0]    w_eff;
    logic [nads_pkg::FH_W-1:0]    fh;
    logic [nads_pkg::FH_W-1:0]    h_eff;

    logic                         accept;
    logic                         flush_step;
    logic                         produce;
    logic                         is_final;
    logic                         out_fire;
    logic [nads_pkg::COL_W-1:0]   cur_col;
    logic                         has_up;
    logic                         has_left;
    logic                         has_right;
    logic [SW-1:0]                sum;
    logic [nads_pkg::TOTAL_W-1:0] total_sum;
    nads_pkg::result_t            res;
    nads_pkg::line_ctl_t          line_ctl;

    logic [PIXEL_BITS-1:0]        a_end;
    logic [PIXEL_BITS-1:0]        a_ahead;
    logic [PIXEL_BITS-1:0]        a_behind;
    logic [PIXEL_BITS-1:0]        b_end;

    nads_line #(
        .DEPTH      (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .IDX_W      (IDX_W)
    ) u_line (
        .clk      (clk),
        .ctl      (line_ctl),
        .ins      (ins_reg),
        .pixel    (pixel),
        .a_end    (a_end),
        .a_ahead  (a_ahead),
        .a_behind (a_behind),
        .b_end    (b_end)
    );

    assign in_stall = skid_valid_reg || flush_active_reg;
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        fw    = cfg_data[nads_pkg::FW_W-1:0];
        w_eff = (fw == '0) ? nads_pkg::FW_W'(1) : ((fw > MAX_W_V) ? MAX_W_V : fw);
        fh    = cfg_data[nads_pkg::FH_W-1:0];
        h_eff = (fh == '0) ? nads_pkg::FH_W'(1)
                           : ((fh > nads_pkg::MAX_HEIGHT) ? nads_pkg::MAX_HEIGHT : fh);
    end

    always_comb
    begin
        flush_step = flush_active_reg && !skid_valid_reg;
        is_final   = (row_reg == last_row_reg) && (col_reg == last_col_reg);
        produce    = flush_step || (accept && (row_reg != '0));
        cur_col    = flush_active_reg ? flush_col_reg : col_reg;
        has_left   = (cur_col != '0);
        has_right  = (cur_col != last_col_reg);
        has_up     = flush_active_reg ? (flush_row_reg != '0)
                                      : (row_reg > nads_pkg::ROW_W'(1));

        sum = (flush_active_reg ? '0 : SW'(absdiff(pixel, a_end)))
            + (has_up    ? SW'(absdiff(b_end, a_end))    : '0)
            + (has_left  ? SW'(absdiff(a_behind, a_end)) : '0)
            + (has_right ? SW'(absdiff(a_ahead, a_end))  : '0);
        total_sum = total_reg + nads_pkg::TOTAL_W'(sum);

        res.row   = flush_active_reg ? flush_row_reg : (row_reg - nads_pkg::ROW_W'(1));
        res.col   = cur_col;
        res.sum   = nads_pkg::SUM_W'(sum);
        res.total = total_sum;
        res.last  = flush_active_reg && (flush_col_reg == last_col_reg);

        line_ctl.shift  = accept || flush_step;
        line_ctl.rotate = flush_active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg     <= nads_pkg::COL_W'(RST_W - 1);
            ins_reg          <= IDX_W'(MAX_WIDTH - RST_W);
            last_row_reg     <= nads_pkg::RST_LAST_ROW;
            row_reg          <= '0;
            col_reg          <= '0;
            total_reg        <= '0;
            flush_active_reg <= 1'b0;
            flush_col_reg    <= '0;
            flush_row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (nads_pkg::cfg_reg_t'(cfg_index))
                nads_pkg::REG_FRAME_WIDTH:
                begin
                    last_col_reg <= nads_pkg::COL_W'(w_eff - nads_pkg::FW_W'(1));
                    ins_reg      <= IDX_W'(MAX_W_V - w_eff);
                end
                nads_pkg::REG_FRAME_HEIGHT:
                begin
                    last_row_reg <= nads_pkg::ROW_W'(h_eff - nads_pkg::FH_W'(1));
                end
                default:
                begin
                    last_row_reg <= last_row_reg;
                end
            endcase
            row_reg          <= '0;
            col_reg          <= '0;
            total_reg        <= '0;
            flush_active_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (is_final)
                begin
                    row_reg          <= '0;
                    col_reg          <= '0;
                    flush_active_reg <= 1'b1;
                    flush_col_reg    <= '0;
                    flush_row_reg    <= row_reg;
                end
                else if (col_reg == last_col_reg)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + nads_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + nads_pkg::COL_W'(1);
                end
            end
            if (flush_step)
            begin
                if (flush_col_reg == last_col_reg)
                begin
                    flush_active_reg <= 1'b0;
                end
                else
                begin
                    flush_col_reg <= flush_col_reg + nads_pkg::COL_W'(1);
                end
            end
            if (produce)
            begin
                total_reg <= res.last ? '0 : total_sum;
            end
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (produce)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (produce)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_reg.row;
    assign out_col      = out_reg.col;
    assign abs_diff_sum = out_reg.sum;
    assign frame_total  = out_reg.total;
    assign frame_last   = out_reg.last;

    `NADS_ASSERT(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held with empty output register")
    `NADS_ASSERT(a_col_in_range, 1'b1, col_reg <= last_col_reg,
        "column counter beyond frame width")
    `NADS_ASSERT(a_flush_counters_clear, flush_active_reg, (row_reg == '0) && (col_reg == '0),
        "position counters not cleared during flush")
    `NADS_ASSERT(a_flush_full_row, $fell(flush_active_reg) && !$past(cfg_write),
        $past(flush_col_reg) == $past(last_col_reg),
        "flush ended before the last column")
    `NADS_ASSERT_NEXT(a_final_starts_flush, accept && is_final && !cfg_write,
        flush_active_reg && (flush_col_reg == '0),
        "final pixel did not start the row flush")

endmodule
